// ===== rtl/core/rnpi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnpi_pkg: shared types and constants for the nearest palette index core
// Color and control types and the RGB565 channel expansion functions
// used by the palette ring, the distance unit and the top level.
// ----------------------------------------------------------------------------
package rnpi_pkg;

    // Request kinds on the input channel
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // One 8:8:8 color, also the layout of a palette entry
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } color_t;

    // Control that travels with each palette entry into the distance unit
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } feed_t;

    // Reset palette: entry i = (7i, 13i, 17i) mod 256
    localparam int RST_MUL_R = 7;
    localparam int RST_MUL_G = 13;
    localparam int RST_MUL_B = 17;

    // 5-bit expansion: v*255/31 = 8v + floor(7v/31)
    localparam logic [7:0]  RB_FRAC_MUL = 8'd7;
    // floor(y/31) = (y*265) >> 13 for y <= 217
    localparam logic [15:0] RECIP_31    = 16'd265;
    localparam int          RECIP_SHIFT = 13;

    // 6-bit expansion: v*255/63 = 4v + floor(v/21)
    localparam logic [5:0]  G_STEP = 6'd21;

    localparam int DIST_W = 18;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [7:0]  y;
        logic [15:0] p;
        begin
            y = 8'({3'b000, v} * RB_FRAC_MUL);
            p = {8'h00, y} * RECIP_31;
            return {v, 3'b000} + 8'(p >> RECIP_SHIFT);
        end
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [1:0] q;
        begin
            if (v >= 6'(3 * G_STEP))
                q = 2'd3;
            else if (v >= 6'(2 * G_STEP))
                q = 2'd2;
            else if (v >= G_STEP)
                q = 2'd1;
            else
                q = 2'd0;
            return {v, 2'b00} + {6'b000000, q};
        end
    endfunction

endpackage

// ===== rtl/core/rnpi_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnpi_cell: one palette entry in the rotating ring
// Holds a 24-bit entry, takes a direct write or shifts in its neighbor's
// entry while the ring rotates during a search.
// ----------------------------------------------------------------------------
module rnpi_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,
    input  logic              wr_en,
    input  rnpi_pkg::color_t  wr_data,
    input  rnpi_pkg::color_t  nb_in,
    output rnpi_pkg::color_t  entry
);

    localparam logic [7:0] RST_R = 8'((CELL_INDEX * rnpi_pkg::RST_MUL_R) % 256);
    localparam logic [7:0] RST_G = 8'((CELL_INDEX * rnpi_pkg::RST_MUL_G) % 256);
    localparam logic [7:0] RST_B = 8'((CELL_INDEX * rnpi_pkg::RST_MUL_B) % 256);

    rnpi_pkg::color_t entry_reg;
    rnpi_pkg::color_t entry_next;

    // write has priority; writes only land while the ring is at rest
    always_comb
    begin
        entry_next = entry_reg;
        if (wr_en)
            entry_next = wr_data;
        else if (shift)
            entry_next = nb_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg.r <= RST_R;
            entry_reg.g <= RST_G;
            entry_reg.b <= RST_B;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/core/rnpi_dist.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnpi_dist: squared distance and running minimum
// Two stages: per-channel squared differences, then sum and strict
// less-than compare against the best so far. Lowest index wins a tie.
// ----------------------------------------------------------------------------
module rnpi_dist #(
    parameter int IDX_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rnpi_pkg::feed_t   feed,
    input  logic [IDX_W-1:0]  feed_idx,
    input  rnpi_pkg::color_t  entry,
    input  rnpi_pkg::color_t  color,
    output logic              done,
    output logic [IDX_W-1:0]  best_index
);

    // stage 1 registers
    rnpi_pkg::feed_t   s1_ctrl_reg;
    rnpi_pkg::feed_t   s1_ctrl_next;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic [15:0]       s1_sq_r_reg;
    logic [15:0]       s1_sq_g_reg;
    logic [15:0]       s1_sq_b_reg;
    logic [15:0]       s1_sq_r_next;
    logic [15:0]       s1_sq_g_next;
    logic [15:0]       s1_sq_b_next;

    // stage 2 registers
    logic [rnpi_pkg::DIST_W-1:0] best_dist_reg;
    logic [rnpi_pkg::DIST_W-1:0] best_dist_next;
    logic [IDX_W-1:0]            best_idx_reg;
    logic [IDX_W-1:0]            best_idx_next;
    logic                        done_reg;
    logic                        done_next;

    logic [7:0]                  dr;
    logic [7:0]                  dg;
    logic [7:0]                  db;
    logic [rnpi_pkg::DIST_W-1:0] dist_sum;
    logic                        take;

    // stage 1: absolute differences and squares
    always_comb
    begin
        dr = (color.r >= entry.r) ? (color.r - entry.r) : (entry.r - color.r);
        dg = (color.g >= entry.g) ? (color.g - entry.g) : (entry.g - color.g);
        db = (color.b >= entry.b) ? (color.b - entry.b) : (entry.b - color.b);
        s1_sq_r_next = {8'h00, dr} * {8'h00, dr};
        s1_sq_g_next = {8'h00, dg} * {8'h00, dg};
        s1_sq_b_next = {8'h00, db} * {8'h00, db};
        s1_ctrl_next = feed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_ctrl_reg <= '0;
        else
            s1_ctrl_reg <= s1_ctrl_next;
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= feed_idx;
        s1_sq_r_reg <= s1_sq_r_next;
        s1_sq_g_reg <= s1_sq_g_next;
        s1_sq_b_reg <= s1_sq_b_next;
    end

    // stage 2: sum, compare, keep the best
    always_comb
    begin
        dist_sum = rnpi_pkg::DIST_W'(s1_sq_r_reg) + rnpi_pkg::DIST_W'(s1_sq_g_reg)
                 + rnpi_pkg::DIST_W'(s1_sq_b_reg);
        take = s1_ctrl_reg.valid && (s1_ctrl_reg.first || (dist_sum < best_dist_reg));
        best_dist_next = take ? dist_sum : best_dist_reg;
        best_idx_next  = take ? s1_idx_reg : best_idx_reg;
        done_next      = s1_ctrl_reg.valid && s1_ctrl_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
    end

    assign done       = done_reg;
    assign best_index = best_idx_reg;

endmodule

// ===== rtl/core/rgb565_nearest_palette_index_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_nearest_palette_index_core: RGB565 pixel to nearest palette index
// Palette held in a ring of entry cells; one shared distance unit scans it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request per beat.
//   req_type 0: rgb565_pixel is expanded to 8:8:8 and every palette entry
//   is scored by squared distance; the lowest-index minimum is returned on
//   the output channel (out_valid / out_stall) as color_index.
//   req_type 1: entry_index/red/green/blue overwrite one palette entry.
//   Writes give no output beat and do not stall the input; an index at or
//   beyond PALETTE_ENTRIES is dropped.
//   The ring rotates one entry per cycle into the single distance unit,
//   and the result passes through the two distance stages and the output
//   register; in_stall is high for the whole scan, so a new pixel is not
//   taken while one is in flight.
//   If the receiver stalls, the result waits in the block and the output
//   register holds; a new pixel is taken once the result has moved into
//   the output register.
//   Reset loads entry i with (7i, 13i, 17i) mod 256 and clears all beats.
// ----------------------------------------------------------------------------
module rgb565_nearest_palette_index_core #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [15:0] rgb565_pixel,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  entry_red,
    input  logic [7:0]  entry_green,
    input  logic [7:0]  entry_blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  color_index
);

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FEED  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [IDX_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  cnt_next;
    rnpi_pkg::color_t  pix_color_reg;
    rnpi_pkg::color_t  pix_color_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        color_index_reg;
    logic [7:0]        color_index_next;

    logic              in_fire;
    logic              pix_fire;
    logic              wr_fire;
    logic              feeding;
    logic              out_free;
    logic              load;
    rnpi_pkg::feed_t   feed;
    rnpi_pkg::color_t  wr_data;
    rnpi_pkg::color_t  cell_entry [PALETTE_ENTRIES];
    logic              dist_done;
    logic [IDX_W-1:0]  best_index;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign pix_fire = in_fire && (req_type == rnpi_pkg::REQ_PIXEL);
    assign wr_fire  = in_fire && (req_type == rnpi_pkg::REQ_WRITE);
    assign feeding  = (state_reg == ST_FEED);
    assign out_free = !out_valid_reg || !out_stall;

    assign wr_data.r = entry_red;
    assign wr_data.g = entry_green;
    assign wr_data.b = entry_blue;

    // palette ring: each cell hands its entry toward cell 0 while scanning
    for (genvar i = 0; i < PALETTE_ENTRIES; i++)
    begin : g_cell
        rnpi_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (feeding),
            .wr_en   (wr_fire && (entry_index == 8'(i))),
            .wr_data (wr_data),
            .nb_in   (cell_entry[(i + 1) % PALETTE_ENTRIES]),
            .entry   (cell_entry[i])
        );
    end

    // head of the ring feeds the distance unit
    always_comb
    begin
        feed.valid = feeding;
        feed.first = (cnt_reg == '0);
        feed.last  = (cnt_reg == LAST_IDX);
    end

    rnpi_dist #(
        .IDX_W (IDX_W)
    ) u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .feed       (feed),
        .feed_idx   (cnt_reg),
        .entry      (cell_entry[0]),
        .color      (pix_color_reg),
        .done       (dist_done),
        .best_index (best_index)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (pix_fire)
                begin
                    state_next = ST_FEED;
                    cnt_next   = '0;
                end
            end
            ST_FEED:
            begin
                cnt_next = IDX_W'(cnt_reg + 1'b1);
                if (cnt_reg == LAST_IDX)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (dist_done)
                begin
                    if (out_free)
                    begin
                        load       = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // pixel expansion on accept
    always_comb
    begin
        pix_color_next = pix_color_reg;
        if (pix_fire)
        begin
            pix_color_next.r = rnpi_pkg::expand5(rgb565_pixel[15:11]);
            pix_color_next.g = rnpi_pkg::expand6(rgb565_pixel[10:5]);
            pix_color_next.b = rnpi_pkg::expand5(rgb565_pixel[4:0]);
        end
    end

    // output register
    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
        color_index_next = load ? 8'(best_index) : color_index_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_color_reg   <= pix_color_next;
        color_index_reg <= color_index_next;
    end

    assign out_valid   = out_valid_reg;
    assign color_index = color_index_reg;

endmodule

// ===== rtl/core/rnpi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnpi_checker: port-level checks for the nearest palette index core
// Watches the two channels of the top level; bound in below.
// ----------------------------------------------------------------------------
module rnpi_checker #(
    parameter int PALETTE_ENTRIES = 256
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        req_type,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  color_index
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(color_index))
        else $error("result beat changed while stalled");

    // a pixel beat starts a scan, so input stalls next cycle
    a_pix_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == rnpi_pkg::REQ_PIXEL) |=> in_stall)
        else $error("pixel beat did not start a scan");

    // a palette write does not stall the input
    a_wr_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == rnpi_pkg::REQ_WRITE) |=> !in_stall)
        else $error("palette write stalled the input");

    // a result only appears at the end of a scan
    a_out_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a scan");

    // returned index is always a real entry
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> color_index <= 8'(PALETTE_ENTRIES - 1))
        else $error("index beyond palette");

endmodule

bind rgb565_nearest_palette_index_core rnpi_checker #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
) u_rnpi_checker (.*);
